// ===== hw/rtl/mdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared sizes, codes, command types and fixed-point helpers for the MDP
// policy iteration core.
// ----------------------------------------------------------------------------
package mdp_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_ACTIONS = 4;
  localparam int SW          = 4;            // state index width
  localparam int AW          = 2;            // action index width
  localparam int COLS        = 2 * NUM_STATES;
  localparam int CW          = 5;            // augmented column index width
  localparam int QW          = 32;
  localparam int GW          = 16;           // discount width
  localparam int RCW         = 4;            // round count width
  localparam int ACCW        = 52;           // dot product accumulator width
  localparam int DIVN        = 48;           // quotient bits of the divider

  localparam int IN_DW  = 48;
  localparam int OUT_DW = 40;

  localparam logic signed [QW-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [QW-1:0] Q_MAX  = 32'sh7fff_ffff;
  localparam logic signed [QW-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic [GW-1:0]  GAMMA_RST    = 16'd58982;
  localparam logic [RCW-1:0] ROUNDS_RST   = 4'd5;

  // Input operation codes (in_tuser).
  localparam logic [1:0] OPC_LOAD_P = 2'd0;
  localparam logic [1:0] OPC_LOAD_R = 2'd1;
  localparam logic [1:0] OPC_SOLVE  = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] CFG_DISCOUNT = 1'b0;
  localparam logic [0:0] CFG_ROUNDS   = 1'b1;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLRV,
    DP_G_RD,
    DP_G_MUL,
    DP_G_ACC,
    DP_G_GMUL,
    DP_G_Q,
    DP_B_RD,
    DP_B_MUL,
    DP_B_WR,
    DP_B_WR2,
    DP_E_RDP,
    DP_E_DIV,
    DP_E_RD,
    DP_E_MUL,
    DP_E_WR,
    DP_N_RDP,
    DP_N_PIV,
    DP_N_RD,
    DP_N_DIV,
    DP_N_WR,
    DP_V_RD,
    DP_V_MUL,
    DP_V_ACC,
    DP_V_WR,
    DP_O_SEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t        op;
    logic [SW-1:0] i;
    logic [SW-1:0] j;
    logic [CW-1:0] k;
    logic [AW-1:0] a;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return Q_MAX;
    end else if (x < -64'sd2147483648) begin
      return Q_MIN;
    end
    return x[QW-1:0];
  endfunction

  // Round a Q32.32 product back to Q16.16: add one half, then floor.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + 64'sd32768;
    return t >>> 16;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mdp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mdp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_div
// Q16.16 divider: (num * 2^16) / den, truncated toward zero and saturated.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mdp_div
  import mdp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [QW-1:0] num,
  input  wire logic signed [QW-1:0] den,
  output logic                      busy,
  output logic signed [QW-1:0]      quo
);

  logic [5:0]      cnt_r;
  logic [DIVN-1:0] dvd_r;
  logic [DIVN-1:0] q_r;
  logic [QW:0]     rem_r;
  logic [QW-1:0]   den_r;
  logic            neg_r;
  logic            zden_r;
  logic            nneg_r;
  logic            nzero_r;

  logic [QW-1:0] num_mag;
  logic [QW-1:0] den_mag;
  logic [QW:0]   rem_sh;
  logic          qbit;

  assign num_mag = num[QW-1] ? (~num + 32'd1) : num;
  assign den_mag = den[QW-1] ? (~den + 32'd1) : den;
  assign rem_sh  = {rem_r[QW-1:0], dvd_r[DIVN-1]};
  assign qbit    = rem_sh >= {1'b0, den_r};
  assign busy    = cnt_r != 6'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= 6'(DIVN);
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r   <= {num_mag, 16'd0};
      q_r     <= '0;
      rem_r   <= '0;
      den_r   <= den_mag;
      neg_r   <= num[QW-1] ^ den[QW-1];
      zden_r  <= den == '0;
      nneg_r  <= num[QW-1];
      nzero_r <= num == '0;
    end else if (busy) begin
      dvd_r <= {dvd_r[DIVN-2:0], 1'b0};
      q_r   <= {q_r[DIVN-2:0], qbit};
      rem_r <= qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
    end
  end

  always_comb begin
    if (zden_r) begin
      quo = nneg_r ? Q_MIN : (nzero_r ? '0 : Q_MAX);
    end else if (neg_r) begin
      quo = (q_r > 48'h0000_8000_0000) ? Q_MIN : (~q_r[QW-1:0] + 32'd1);
    end else begin
      quo = (q_r > 48'h0000_7fff_ffff) ? Q_MAX : q_r[QW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mdp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_datapath
// Stores, shared multiplier, accumulator, divider, value and policy
// registers and the output word register of the MDP core.
// ----------------------------------------------------------------------------
module mdp_datapath
  import mdp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic [1:0]        in_tuser,
  input  wire logic [IN_DW-1:0]  in_tdata,
  input  wire logic              cfg_wen,
  input  wire logic [0:0]        cfg_addr,
  input  wire logic [GW-1:0]     cfg_wdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,
  output logic                   out_tlast
);

  logic [GW-1:0] gamma_r;

  logic signed [QW-1:0] v_r     [NUM_STATES];
  logic [AW-1:0]        pol_r   [NUM_STATES];
  logic signed [QW-1:0] bestv_r [NUM_STATES];

  logic signed [63:0]   prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [QW-1:0] best_r;
  logic [AW-1:0]        bact_r;
  logic signed [QW-1:0] piv_r;

  logic                 out_valid_r;
  logic [SW-1:0]        out_state_r;
  logic [AW-1:0]        out_act_r;
  logic signed [QW-1:0] out_val_r;
  logic                 out_last_r;

  // Input word fields.
  logic [SW-1:0] ld_from;
  logic [SW-1:0] ld_to;
  logic [AW-1:0] ld_act;
  logic [QW-1:0] ld_val;
  assign ld_from = in_tdata[3:0];
  assign ld_to   = in_tdata[7:4];
  assign ld_act  = in_tdata[9:8];
  assign ld_val  = in_tdata[41:10];

  // Store ports.
  logic          tr_we;
  logic [9:0]    tr_waddr;
  logic [9:0]    tr_raddr;
  logic [QW-1:0] tr_rdata;
  logic          rw_we;
  logic [5:0]    rw_waddr;
  logic [5:0]    rw_raddr;
  logic [QW-1:0] rw_rdata;
  logic          mx_we;
  logic [8:0]    mx_waddr;
  logic [QW-1:0] mx_wdata;
  logic [8:0]    ma_raddr;
  logic [8:0]    mb_raddr;
  logic [QW-1:0] ma_rdata;
  logic [QW-1:0] mb_rdata;

  logic          div_start;
  logic [QW-1:0] div_num;
  logic [QW-1:0] div_den;
  logic          div_busy;
  logic signed [QW-1:0] div_quo;

  logic [SW-1:0] pol_idx;
  logic [AW-1:0] pol_sel;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] rnd_w;
  logic signed [QW-1:0] qm_w;
  logic signed [QW-1:0] acc_sat;
  logic signed [QW-1:0] q_w;
  logic                 take_w;
  logic signed [QW-1:0] nbest;
  logic [AW-1:0]        nact;
  logic signed [QW-1:0] id_w;
  logic                 first_k;

  assign first_k = cmd.k == '0;
  assign pol_idx = (cmd.op == DP_V_RD) ? cmd.k[SW-1:0] : cmd.i;
  assign pol_sel = pol_r[pol_idx];
  assign id_w    = (cmd.i == cmd.j) ? Q_ONE : '0;

  mdp_ram #(.WIDTH(QW), .DEPTH(NUM_STATES * NUM_STATES * NUM_ACTIONS)) u_tran (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(ld_val),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );

  mdp_ram #(.WIDTH(QW), .DEPTH(NUM_STATES * NUM_ACTIONS)) u_rew (
    .clk(clk), .we(rw_we), .waddr(rw_waddr), .wdata(ld_val),
    .raddr(rw_raddr), .rdata(rw_rdata)
  );

  // The augmented matrix is kept in two copies so that a pivot-row element
  // and a target-row element can be read in the same cycle.
  mdp_ram #(.WIDTH(QW), .DEPTH(NUM_STATES * COLS)) u_mat_a (
    .clk(clk), .we(mx_we), .waddr(mx_waddr), .wdata(mx_wdata),
    .raddr(ma_raddr), .rdata(ma_rdata)
  );

  mdp_ram #(.WIDTH(QW), .DEPTH(NUM_STATES * COLS)) u_mat_b (
    .clk(clk), .we(mx_we), .waddr(mx_waddr), .wdata(mx_wdata),
    .raddr(mb_raddr), .rdata(mb_rdata)
  );

  mdp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
  );

  assign tr_we    = (cmd.op == DP_LOAD) && (in_tuser == OPC_LOAD_P);
  assign tr_waddr = {ld_from, ld_to, ld_act};
  assign rw_we    = (cmd.op == DP_LOAD) && (in_tuser == OPC_LOAD_R);
  assign rw_waddr = {ld_from, ld_act};

  assign tr_raddr = (cmd.op == DP_B_RD) ? {cmd.i, cmd.j, pol_sel}
                                        : {cmd.i, cmd.k[SW-1:0], cmd.a};
  assign rw_raddr = (cmd.op == DP_V_RD) ? {cmd.k[SW-1:0], pol_sel} : {cmd.i, cmd.a};

  always_comb begin
    case (cmd.op)
      DP_E_RDP, DP_N_RDP: ma_raddr = {cmd.i, 1'b0, cmd.i};
      DP_V_RD:            ma_raddr = {cmd.i, 1'b1, cmd.k[SW-1:0]};
      default:            ma_raddr = {cmd.i, cmd.k};
    endcase
    mb_raddr = (cmd.op == DP_E_RDP) ? {cmd.j, 1'b0, cmd.i} : {cmd.j, cmd.k};
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = $signed({tr_rdata[QW-1], tr_rdata});
    mul_b = $signed({v_r[cmd.k[SW-1:0]][QW-1], v_r[cmd.k[SW-1:0]]});
    case (cmd.op)
      DP_G_GMUL: begin
        mul_a = $signed({acc_sat[QW-1], acc_sat});
        mul_b = $signed({17'd0, gamma_r});
      end
      DP_B_MUL: begin
        mul_b = $signed({17'd0, gamma_r});
      end
      DP_E_MUL: begin
        mul_a = $signed({div_quo[QW-1], div_quo});
        mul_b = $signed({ma_rdata[QW-1], ma_rdata});
      end
      DP_V_MUL: begin
        mul_a = $signed({ma_rdata[QW-1], ma_rdata});
        mul_b = $signed({rw_rdata[QW-1], rw_rdata});
      end
      default: begin
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign rnd_w   = rnd16(prod_r);
  assign qm_w    = sat32(rnd_w);
  assign acc_sat = sat32($signed({{(64 - ACCW){acc_r[ACCW-1]}}, acc_r}));
  assign q_w     = sat32($signed({{32{rw_rdata[QW-1]}}, rw_rdata})
                       + $signed({{32{qm_w[QW-1]}}, qm_w}));
  assign take_w  = (cmd.a == '0) || (q_w >= best_r);
  assign nbest   = take_w ? q_w : best_r;
  assign nact    = take_w ? cmd.a : bact_r;

  // Matrix writes.
  always_comb begin
    mx_we    = 1'b0;
    mx_waddr = {cmd.i, cmd.k};
    mx_wdata = div_quo;
    case (cmd.op)
      DP_B_WR: begin
        mx_we    = 1'b1;
        mx_waddr = {cmd.i, 1'b0, cmd.j};
        mx_wdata = sat32($signed({{32{id_w[QW-1]}}, id_w})
                         - $signed({{32{qm_w[QW-1]}}, qm_w}));
      end
      DP_B_WR2: begin
        mx_we    = 1'b1;
        mx_waddr = {cmd.i, 1'b1, cmd.j};
        mx_wdata = id_w;
      end
      DP_E_WR: begin
        mx_we    = 1'b1;
        mx_waddr = {cmd.j, cmd.k};
        mx_wdata = sat32($signed({{32{mb_rdata[QW-1]}}, mb_rdata})
                         - $signed({{32{qm_w[QW-1]}}, qm_w}));
      end
      DP_N_WR: begin
        mx_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign div_start = (cmd.op == DP_E_DIV) || (cmd.op == DP_N_DIV);
  assign div_num   = (cmd.op == DP_E_DIV) ? mb_rdata : ma_rdata;
  assign div_den   = (cmd.op == DP_E_DIV) ? ma_rdata : piv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RST;
    end else if (cfg_wen && cfg_addr == CFG_DISCOUNT) begin
      gamma_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NUM_STATES; n++) begin
        v_r[n]   <= '0;
        pol_r[n] <= '0;
      end
    end else begin
      if (cmd.op == DP_CLRV) begin
        for (int n = 0; n < NUM_STATES; n++) begin
          v_r[n] <= '0;
        end
      end
      if (cmd.op == DP_V_WR) begin
        v_r[cmd.i] <= acc_sat;
      end
      if (cmd.op == DP_G_Q && cmd.a == AW'(NUM_ACTIONS - 1)) begin
        pol_r[cmd.i] <= nact;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_G_MUL || cmd.op == DP_G_GMUL || cmd.op == DP_B_MUL
        || cmd.op == DP_E_MUL || cmd.op == DP_V_MUL) begin
      prod_r <= mul_p[63:0];
    end
    if (cmd.op == DP_G_ACC || cmd.op == DP_V_ACC) begin
      acc_r <= (first_k ? '0 : acc_r) + rnd_w[ACCW-1:0];
    end
    if (cmd.op == DP_G_Q) begin
      best_r <= nbest;
      bact_r <= nact;
      if (cmd.a == AW'(NUM_ACTIONS - 1)) begin
        bestv_r[cmd.i] <= nbest;
      end
    end
    if (cmd.op == DP_N_PIV) begin
      piv_r <= ma_rdata;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_O_SEND) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_O_SEND) begin
      out_state_r <= cmd.i;
      out_act_r   <= pol_r[cmd.i];
      out_val_r   <= bestv_r[cmd.i];
      out_last_r  <= cmd.i == SW'(NUM_STATES - 1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r, out_act_r, out_state_r};
  assign out_tlast  = out_last_r;

  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid_r || out_tready;

endmodule
`default_nettype wire

// ===== hw/rtl/mdp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_ctrl
// Sequencer for the solve: greedy step, policy evaluation by Gauss-Jordan
// elimination, improvement rounds and result delivery.
// ----------------------------------------------------------------------------
module mdp_ctrl
  import mdp_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [1:0]     in_tuser,
  input  wire logic           cfg_wen,
  input  wire logic [0:0]     cfg_addr,
  input  wire logic [RCW-1:0] cfg_rounds,
  input  wire dp_stat_t       stat,
  output dp_cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CLRV,
    S_G_RD, S_G_MUL, S_G_ACC, S_G_GMUL, S_G_Q,
    S_B_RD, S_B_MUL, S_B_WR, S_B_WR2,
    S_E_RDP, S_E_DIV, S_E_WAIT, S_E_RD, S_E_MUL, S_E_WR,
    S_N_RDP, S_N_PIV, S_N_RD, S_N_DIV, S_N_WAIT, S_N_WR,
    S_V_RD, S_V_MUL, S_V_ACC, S_V_WR,
    S_OUT
  } state_t;

  state_t         state_r;
  logic [SW-1:0]  i_r;
  logic [SW:0]    j_r;
  logic [CW-1:0]  k_r;
  logic [AW-1:0]  a_r;
  logic [RCW-1:0] rnd_r;
  logic [RCW-1:0] rounds_r;

  localparam logic [SW-1:0] I_LAST = SW'(NUM_STATES - 1);
  localparam logic [CW-1:0] K_LAST = CW'(NUM_STATES - 1);
  localparam logic [CW-1:0] C_LAST = CW'(COLS - 1);
  localparam logic [AW-1:0] A_LAST = AW'(NUM_ACTIONS - 1);

  // Next target row in elimination, skipping the pivot row.
  logic [SW:0] j_inc;
  logic [SW:0] j_nx;
  assign j_inc = j_r + 1'b1;
  assign j_nx  = (j_inc[SW-1:0] == i_r && !j_inc[SW]) ? j_r + 2'd2 : j_inc;

  assign in_tready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      a_r      <= '0;
      rnd_r    <= '0;
      rounds_r <= ROUNDS_RST;
    end else begin
      if (cfg_wen && cfg_addr == CFG_ROUNDS) begin
        rounds_r <= cfg_rounds;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tuser == OPC_SOLVE) begin
            state_r <= S_CLRV;
          end
        end
        S_CLRV: begin
          i_r     <= '0;
          k_r     <= '0;
          a_r     <= '0;
          rnd_r   <= '0;
          state_r <= S_G_RD;
        end
        S_G_RD:  state_r <= S_G_MUL;
        S_G_MUL: state_r <= S_G_ACC;
        S_G_ACC: begin
          if (k_r == K_LAST) begin
            k_r     <= '0;
            state_r <= S_G_GMUL;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_G_RD;
          end
        end
        S_G_GMUL: state_r <= S_G_Q;
        S_G_Q: begin
          a_r     <= a_r + 1'b1;
          state_r <= S_G_RD;
          if (a_r == A_LAST) begin
            i_r <= i_r + 1'b1;
            if (i_r == I_LAST) begin
              j_r <= '0;
              if (rnd_r == rounds_r) begin
                state_r <= S_OUT;
              end else begin
                rnd_r   <= rnd_r + 1'b1;
                state_r <= S_B_RD;
              end
            end
          end
        end
        S_B_RD:  state_r <= S_B_MUL;
        S_B_MUL: state_r <= S_B_WR;
        S_B_WR:  state_r <= S_B_WR2;
        S_B_WR2: begin
          state_r <= S_B_RD;
          if (j_r[SW-1:0] == I_LAST) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
            if (i_r == I_LAST) begin
              j_r     <= (SW + 1)'(1);
              state_r <= S_E_RDP;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_E_RDP: state_r <= S_E_DIV;
        S_E_DIV: state_r <= S_E_WAIT;
        S_E_WAIT: begin
          if (!stat.div_busy) begin
            k_r     <= '0;
            state_r <= S_E_RD;
          end
        end
        S_E_RD:  state_r <= S_E_MUL;
        S_E_MUL: state_r <= S_E_WR;
        S_E_WR: begin
          if (k_r == C_LAST) begin
            k_r     <= '0;
            state_r <= S_E_RDP;
            if (j_nx[SW]) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
              if (i_r == I_LAST) begin
                state_r <= S_N_RDP;
              end
            end else begin
              j_r <= j_nx;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_E_RD;
          end
        end
        S_N_RDP: state_r <= S_N_PIV;
        S_N_PIV: state_r <= S_N_RD;
        S_N_RD:  state_r <= S_N_DIV;
        S_N_DIV: state_r <= S_N_WAIT;
        S_N_WAIT: begin
          if (!stat.div_busy) begin
            state_r <= S_N_WR;
          end
        end
        S_N_WR: begin
          if (k_r == C_LAST) begin
            k_r     <= '0;
            i_r     <= i_r + 1'b1;
            state_r <= (i_r == I_LAST) ? S_V_RD : S_N_RDP;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_N_RD;
          end
        end
        S_V_RD:  state_r <= S_V_MUL;
        S_V_MUL: state_r <= S_V_ACC;
        S_V_ACC: begin
          if (k_r == K_LAST) begin
            state_r <= S_V_WR;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_V_RD;
          end
        end
        S_V_WR: begin
          k_r     <= '0;
          a_r     <= '0;
          i_r     <= i_r + 1'b1;
          state_r <= (i_r == I_LAST) ? S_G_RD : S_V_RD;
        end
        S_OUT: begin
          if (stat.out_free) begin
            i_r <= i_r + 1'b1;
            if (i_r == I_LAST) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.i = i_r;
    cmd.j = j_r[SW-1:0];
    cmd.k = k_r;
    cmd.a = a_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.op = (in_tvalid && (in_tuser == OPC_LOAD_P || in_tuser == OPC_LOAD_R))
                 ? DP_LOAD : DP_NOP;
      end
      S_CLRV:   cmd.op = DP_CLRV;
      S_G_RD:   cmd.op = DP_G_RD;
      S_G_MUL:  cmd.op = DP_G_MUL;
      S_G_ACC:  cmd.op = DP_G_ACC;
      S_G_GMUL: cmd.op = DP_G_GMUL;
      S_G_Q:    cmd.op = DP_G_Q;
      S_B_RD:   cmd.op = DP_B_RD;
      S_B_MUL:  cmd.op = DP_B_MUL;
      S_B_WR:   cmd.op = DP_B_WR;
      S_B_WR2:  cmd.op = DP_B_WR2;
      S_E_RDP:  cmd.op = DP_E_RDP;
      S_E_DIV:  cmd.op = DP_E_DIV;
      S_E_RD:   cmd.op = DP_E_RD;
      S_E_MUL:  cmd.op = DP_E_MUL;
      S_E_WR:   cmd.op = DP_E_WR;
      S_N_RDP:  cmd.op = DP_N_RDP;
      S_N_PIV:  cmd.op = DP_N_PIV;
      S_N_RD:   cmd.op = DP_N_RD;
      S_N_DIV:  cmd.op = DP_N_DIV;
      S_N_WR:   cmd.op = DP_N_WR;
      S_V_RD:   cmd.op = DP_V_RD;
      S_V_MUL:  cmd.op = DP_V_MUL;
      S_V_ACC:  cmd.op = DP_V_ACC;
      S_V_WR:   cmd.op = DP_V_WR;
      S_OUT:    cmd.op = stat.out_free ? DP_O_SEND : DP_NOP;
      default:  cmd.op = DP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mdp_policy_iteration_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mdp_policy_iteration_core
// Finite MDP solver by policy iteration in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Load words (transition probability or reward) are taken one per cycle while
// the block is idle and written straight into the stores. A solve word
// runs one greedy Bellman step from zero values and then round_count
// evaluate-and-improve rounds; the block takes no input word until the last
// of its 16 result words has been handed to the output register. A greedy
// step runs its multiply-accumulates through a shared 33x33 multiplier. A
// round is dominated by the Gauss-Jordan elimination and normalization,
// where each of the 752 quotients goes through a bit-serial divider and each
// of the 7,680 matrix updates is read, multiplied and written back on the
// single-write matrix store.
// ----------------------------------------------------------------------------
module mdp_policy_iteration_core
  import mdp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // from_state, to_state, action_index, element_value
  input  wire logic [1:0]        in_tuser,   // operation
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // state_index, best_action, state_value
  output logic                   out_tlast,
  input  wire logic              cfg_wen,
  input  wire logic [0:0]        cfg_addr,
  input  wire logic [GW-1:0]     cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mdp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_rounds(cfg_wdata[RCW-1:0]),
    .stat(stat), .cmd(cmd)
  );

  mdp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MDP policy iteration core: loads transition
// and reward stores, runs solves under several discount and round settings,
// and compares every result word with an in-bench policy iteration solver.
// ----------------------------------------------------------------------------
module tb;
  import mdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [SW-1:0] state_index;
    logic [AW-1:0] best_action;
    logic [QW-1:0] state_value;
    logic          last_state;
  } policy_word_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic [1:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;
  logic              cfg_wen;
  logic [0:0]        cfg_addr;
  logic [GW-1:0]     cfg_wdata;

  mdp_policy_iteration_core uut (.*);

  // Solver state kept by the bench.
  int tprob [NUM_STATES][NUM_STATES][NUM_ACTIONS];
  int rwd   [NUM_STATES][NUM_ACTIONS];
  int qtab  [NUM_STATES][NUM_ACTIONS];
  int vals  [NUM_STATES];
  int pol   [NUM_STATES];
  int mtx   [NUM_STATES][COLS];
  int gamma_q;
  int rounds;

  policy_word_t expected_policy[$];
  int errors;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  bit hold_used;
  int hold_cnt;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint rnd_q(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic int sat_q(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int mul_q(int a, int b);
    return sat_q(rnd_q(longint'(a) * longint'(b)));
  endfunction

  function automatic int disc_q(int a);
    return sat_q(rnd_q(longint'(a) * longint'(gamma_q)));
  endfunction

  function automatic int div_q(int a, int b);
    if (b == 0) begin
      if (a > 0) return 32'sh7fffffff;
      if (a < 0) return 32'sh80000000;
      return 0;
    end
    return sat_q((longint'(a) * 64'sd65536) / longint'(b));
  endfunction

  function automatic void bellman_step();
    longint s;
    int q;
    int best;
    for (int i = 0; i < NUM_STATES; i++) begin
      best = 0;
      pol[i] = 0;
      for (int a = 0; a < NUM_ACTIONS; a++) begin
        s = 0;
        for (int k = 0; k < NUM_STATES; k++)
          s += rnd_q(longint'(tprob[i][k][a]) * longint'(vals[k]));
        q = sat_q(longint'(rwd[i][a]) + longint'(disc_q(sat_q(s))));
        qtab[i][a] = q;
        if (a == 0 || q >= best) begin
          best = q;
          pol[i] = a;
        end
      end
    end
  endfunction

  // Gauss-Jordan without pivoting on I - gamma * P_policy, then V = inv * R.
  function automatic void evaluate_values();
    int ratio;
    int piv;
    longint s;
    for (int i = 0; i < NUM_STATES; i++)
      for (int j = 0; j < NUM_STATES; j++) begin
        mtx[i][j] = sat_q(((i == j) ? 64'sd65536 : 64'sd0)
                          - longint'(disc_q(tprob[i][j][pol[i]])));
        mtx[i][NUM_STATES+j] = (i == j) ? 65536 : 0;
      end
    for (int i = 0; i < NUM_STATES; i++)
      for (int j = 0; j < NUM_STATES; j++) begin
        if (i != j) begin
          ratio = div_q(mtx[j][i], mtx[i][i]);
          for (int k = 0; k < COLS; k++)
            mtx[j][k] = sat_q(longint'(mtx[j][k]) - longint'(mul_q(ratio, mtx[i][k])));
        end
      end
    for (int i = 0; i < NUM_STATES; i++) begin
      piv = mtx[i][i];
      for (int k = 0; k < COLS; k++)
        mtx[i][k] = div_q(mtx[i][k], piv);
    end
    for (int i = 0; i < NUM_STATES; i++) begin
      s = 0;
      for (int k = 0; k < NUM_STATES; k++)
        s += rnd_q(longint'(mtx[i][NUM_STATES+k]) * longint'(rwd[k][pol[k]]));
      vals[i] = sat_q(s);
    end
  endfunction

  function automatic void predict_policy();
    policy_word_t w;
    for (int i = 0; i < NUM_STATES; i++) vals[i] = 0;
    bellman_step();
    for (int r = 0; r < rounds; r++) begin
      evaluate_values();
      bellman_step();
    end
    for (int i = 0; i < NUM_STATES; i++) begin
      w.state_index = SW'(i);
      w.best_action = AW'(pol[i]);
      w.state_value = qtab[i][pol[i]];
      w.last_state  = (i == NUM_STATES - 1);
      expected_policy.push_back(w);
    end
  endfunction

  function automatic void apply_word(logic [1:0] op, int fs, int ts, int ac, int v);
    case (op)
      OPC_LOAD_P: tprob[fs][ts][ac] = v;
      OPC_LOAD_R: rwd[fs][ac] = v;
      OPC_SOLVE:  predict_policy();
      default: ;
    endcase
  endfunction

  task automatic send_word(logic [1:0] op, int fs, int ts, int ac, int v);
    while (($urandom % 100) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, v[31:0], ac[1:0], ts[3:0], fs[3:0]};
    do @(posedge clk); while (!in_tready);
    apply_word(op, fs, ts, ac, v);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected result word, then let the core settle.
  task automatic wait_idle();
    end_burst();
    while (expected_policy.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int v);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v[GW-1:0];
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    if (idx == CFG_DISCOUNT) gamma_q = v & 16'hffff;
    else rounds = v & 4'hf;
  endtask

  function automatic int rand_prob();
    return ($urandom % 8) == 0 ? int'($urandom) : int'($urandom_range(0, 8192));
  endfunction

  task automatic test_fill_stores();
    for (int i = 0; i < NUM_STATES; i++)
      for (int a = 0; a < NUM_ACTIONS; a++) begin
        for (int k = 0; k < NUM_STATES; k++)
          send_word(OPC_LOAD_P, i, k, a, $urandom_range(0, 65536 / NUM_STATES));
        send_word(OPC_LOAD_R, i, 0, a, $urandom_range(0, 131072) - 65536);
      end
  endtask

  task automatic test_extremes();
    send_word(OPC_LOAD_P, 15, 15, 3, 32'sh7fffffff);
    send_word(OPC_LOAD_P, 15, 0, 3, 32'sh80000000);
    send_word(OPC_LOAD_R, 15, 0, 3, 32'sh7fffffff);
    send_word(OPC_LOAD_R, 14, 0, 2, 32'sh80000000);
    send_word(OPC_LOAD_R, 13, 0, 1, -1);
    send_word(OPC_UNUSED, 15, 15, 3, int'($urandom));
    wait_idle();
    write_reg(CFG_DISCOUNT, 0);
    write_reg(CFG_ROUNDS, 1);
    send_word(OPC_SOLVE, 0, 0, 0, 0);
    wait_idle();
  endtask

  // With gamma at its maximum, a self-transition of 65537 makes the pivot zero.
  task automatic test_zero_pivot();
    for (int a = 0; a < NUM_ACTIONS; a++) send_word(OPC_LOAD_P, 0, 0, a, 65537);
    wait_idle();
    write_reg(CFG_DISCOUNT, 65535);
    send_word(OPC_SOLVE, 0, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_max_rounds();
    for (int a = 0; a < NUM_ACTIONS; a++)
      send_word(OPC_LOAD_P, 0, 0, a, $urandom_range(0, 65536 / NUM_STATES));
    for (int a = 0; a < NUM_ACTIONS; a++)
      send_word(OPC_LOAD_P, 15, 15 - 15 * (a / 3), a, $urandom_range(0, 4096));
    wait_idle();
    write_reg(CFG_DISCOUNT, 58982);
    write_reg(CFG_ROUNDS, 15);
    send_word(OPC_SOLVE, 0, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_random_phase(int idle, int stall, bit hold);
    int n;
    idle_pct  = idle;
    stall_pct = stall;
    write_reg(CFG_DISCOUNT, $urandom_range(0, 65535));
    write_reg(CFG_ROUNDS, $urandom_range(1, 2));
    n = $urandom_range(20, 30);
    for (int i = 0; i < n; i++) begin
      if (($urandom % 20) == 0)
        send_word(OPC_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 3), int'($urandom));
      else if (($urandom % 5) == 0)
        send_word(OPC_LOAD_R, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 3), ($urandom % 8) == 0 ? int'($urandom)
                  : $urandom_range(0, 131072) - 65536);
      else
        send_word(OPC_LOAD_P, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 3), rand_prob());
    end
    hold_req = hold;
    send_word(OPC_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 3), int'($urandom));
    // Keep offering loads behind the solve so the input stalls.
    for (int i = 0; i < 6; i++)
      send_word(OPC_LOAD_P, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 3), rand_prob());
    wait_idle();
  endtask

  // Result side: check each accepted word, then pick next ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_policy.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        policy_word_t e;
        e = expected_policy.pop_front();
        if (out_tdata[3:0] !== e.state_index) begin
          $error("state_index exp %0d got %0d", e.state_index, out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[5:4] !== e.best_action) begin
          $error("best_action exp %0d got %0d", e.best_action, out_tdata[5:4]);
          errors++;
        end
        if (out_tdata[37:6] !== e.state_value) begin
          $error("state_value exp %h got %h", e.state_value, out_tdata[37:6]);
          errors++;
        end
        if (out_tlast !== e.last_state) begin
          $error("last_state exp %0d got %0d", e.last_state, out_tlast);
          errors++;
        end
      end
    end
    if (hold_req && !hold_used && out_tvalid) begin
      hold_used = 1'b1;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (($urandom % 100) >= stall_pct);
    end
  end

  initial begin
    #100_000_000;
    $display("[mdp_policy_iteration_core] ERROR");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    out_tready = 1'b0;
    cfg_wen   = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    errors    = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    hold_used = 1'b0;
    hold_cnt  = 0;
    gamma_q   = 58982;
    rounds    = 5;
    for (int i = 0; i < NUM_STATES; i++) begin
      vals[i] = 0;
      pol[i]  = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_stores();
    test_extremes();
    test_zero_pivot();
    test_max_rounds();
    test_random_phase(0, 0, 1'b0);
    test_random_phase(55, 0, 1'b1);
    test_random_phase(0, 55, 1'b0);
    test_random_phase(22, 22, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[mdp_policy_iteration_core] OK");
    end else begin
      $display("[mdp_policy_iteration_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== mdp_policy_iteration_core.f =====
hw/rtl/mdp_pkg.sv
hw/rtl/mdp_ram.sv
hw/rtl/mdp_div.sv
hw/rtl/mdp_datapath.sv
hw/rtl/mdp_ctrl.sv
hw/rtl/mdp_policy_iteration_core.sv
tb/sv/tb.sv
